[rtl/bfa_pkg.sv]
// Shared constants and types for the best-fit block allocator.
package bfa_pkg;

    // Table geometry
    localparam int BLOCKS    = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_BITS  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_BITS  = $clog2(BLOCKS + 1);

    // Field widths of the channels and the register
    localparam int SLOT_BITS   = 4;
    localparam int AMOUNT_BITS = 16;
    localparam int CHOSEN_BITS = 4;
    localparam int LEFT_BITS   = 16;
    localparam int COUNT_BITS  = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(16);

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

endpackage

[rtl/bfa_req_if.sv]
// Request channel: load and allocate items.
interface bfa_req_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [bfa_pkg::SLOT_BITS-1:0]    block_slot;
    logic [bfa_pkg::AMOUNT_BITS-1:0]  amount;

    modport source (output valid, kind, block_slot, amount, input ready);
    modport sink   (input valid, kind, block_slot, amount, output ready);
endinterface

[rtl/bfa_rsp_if.sv]
// Response channel: allocation results.
interface bfa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             granted;
    logic [bfa_pkg::CHOSEN_BITS-1:0]  chosen_block;
    logic [bfa_pkg::LEFT_BITS-1:0]    leftover;

    modport source (output valid, granted, chosen_block, leftover, input ready);
    modport sink   (input valid, granted, chosen_block, leftover, output ready);
endinterface

[rtl/bfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [ADDR_BITS-1:0]   waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic [ADDR_BITS-1:0]   raddr,
    output logic [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/best_fit_block_allocator_unit.sv]
// Best-fit block allocator: sequencer, scan compare unit and result register.
//
// Usage:
//   req carries load items (kind 0: write amount as the size of block_slot and
//   mark it free) and allocate items (kind 1: find the free block among the
//   first block_count blocks whose size minus amount is smallest and not
//   negative; lowest index wins a tie). Each allocate produces one transfer on
//   rsp: granted, chosen_block and leftover (index and leftover are zero when
//   nothing fits). Load items produce no response.
//   cfg_we/cfg_wdata write block_count; write it only while the unit is idle.
// Sequence:
//   req.ready stays high through a load, so loads run back to back while no
//   allocate is in progress. An allocate steps through accept, scan (the size
//   RAM read port and the shared subtract/compare unit take the first limit
//   blocks in turn), drain (covers the RAM read latency) and commit.
//   limit is block_count capped at the table depth; zero skips scan and drain.
// Reset: all blocks free, block_count = 16, no response pending. Block sizes
//   are unknown until loaded.
// Stall: the result sits in an output register; a new item is accepted while
//   it waits, and a later commit waits only if that register is still full.
module best_fit_block_allocator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    bfa_req_if.sink                           req,
    bfa_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [bfa_pkg::COUNT_BITS-1:0]    cfg_wdata
);

    // State and working registers
    bfa_pkg::state_t                   state_reg, state_next;
    logic [bfa_pkg::COUNT_BITS-1:0]    count_reg;
    logic [bfa_pkg::BLOCKS-1:0]        used_reg, used_next;
    logic [bfa_pkg::SIZE_BITS-1:0]     request_reg, request_next;
    logic [bfa_pkg::CNT_BITS-1:0]      limit_reg, limit_next;
    logic [bfa_pkg::IDX_BITS-1:0]      scan_idx_reg, scan_idx_next;
    logic [bfa_pkg::IDX_BITS-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                              cmp_valid_reg, cmp_valid_next;
    logic                              found_reg, found_next;
    logic [bfa_pkg::IDX_BITS-1:0]      best_idx_reg, best_idx_next;
    logic [bfa_pkg::SIZE_BITS-1:0]     best_left_reg, best_left_next;

    // Result register
    logic                              out_valid_reg, out_valid_next;
    logic                              out_granted_reg, out_granted_next;
    logic [bfa_pkg::CHOSEN_BITS-1:0]   out_chosen_reg, out_chosen_next;
    logic [bfa_pkg::LEFT_BITS-1:0]     out_left_reg, out_left_next;

    // RAM ports
    logic                              ram_we;
    logic [bfa_pkg::IDX_BITS-1:0]      ram_waddr;
    logic [bfa_pkg::SIZE_BITS-1:0]     ram_wdata;
    logic [bfa_pkg::SIZE_BITS-1:0]     ram_rdata;

    // Compare unit signals
    logic                              cand_free;
    logic                              cand_fits;
    logic [bfa_pkg::SIZE_BITS-1:0]     cand_left;
    logic                              cand_take;
    logic [bfa_pkg::SIZE_BITS-1:0]     req_amount;
    logic [bfa_pkg::CNT_BITS-1:0]      cap_limit;
    logic [bfa_pkg::CNT_BITS-1:0]      scan_next_count;
    logic                              req_fire;
    logic                              commit_fire;

    // Block size storage
    bfa_ram #(
        .WIDTH (bfa_pkg::SIZE_BITS),
        .DEPTH (bfa_pkg::BLOCKS)
    ) u_sizes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // Handshake
    assign req.ready   = (state_reg == bfa_pkg::ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign commit_fire = (state_reg == bfa_pkg::ST_COMMIT) && (!out_valid_reg || rsp.ready);

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted      = out_granted_reg;
    assign rsp.chosen_block = out_chosen_reg;
    assign rsp.leftover     = out_left_reg;

    // Request size in table width, block count capped at the table depth
    assign req_amount = bfa_pkg::SIZE_BITS'(req.amount);
    assign cap_limit  = (32'(count_reg) > 32'(bfa_pkg::BLOCKS))
                      ? bfa_pkg::CNT_BITS'(bfa_pkg::BLOCKS)
                      : bfa_pkg::CNT_BITS'(count_reg);

    assign scan_next_count = bfa_pkg::CNT_BITS'(scan_idx_reg) + bfa_pkg::CNT_BITS'(1);

    // Load path into the size RAM
    assign ram_we    = req_fire && (req.kind == bfa_pkg::KIND_LOAD)
                    && (32'(req.block_slot) < 32'(bfa_pkg::BLOCKS));
    assign ram_waddr = bfa_pkg::IDX_BITS'(req.block_slot);
    assign ram_wdata = req_amount;

    // Shared subtract/compare unit: one candidate block per cycle
    assign cand_free = !used_reg[cmp_idx_reg];
    assign cand_fits = (ram_rdata >= request_reg);
    assign cand_left = ram_rdata - request_reg;
    assign cand_take = cmp_valid_reg && cand_free && cand_fits
                    && (!found_reg || (cand_left < best_left_reg));

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        request_next     = request_reg;
        limit_next       = limit_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmp_valid_next   = 1'b0;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_left_next   = best_left_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_granted_next = out_granted_reg;
        out_chosen_next  = out_chosen_reg;
        out_left_next    = out_left_reg;

        // Best-so-far update
        if (cand_take)
        begin
            found_next     = 1'b1;
            best_idx_next  = cmp_idx_reg;
            best_left_next = cand_left;
        end

        case (state_reg)
            bfa_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.kind == bfa_pkg::KIND_LOAD)
                    begin
                        if (ram_we)
                        begin
                            used_next[ram_waddr] = 1'b0;
                        end
                    end
                    else
                    begin
                        request_next  = req_amount;
                        limit_next    = cap_limit;
                        scan_idx_next = '0;
                        found_next    = 1'b0;
                        if (cap_limit == '0)
                        begin
                            state_next = bfa_pkg::ST_COMMIT;
                        end
                        else
                        begin
                            state_next = bfa_pkg::ST_SCAN;
                        end
                    end
                end
            end

            bfa_pkg::ST_SCAN:
            begin
                // Issue one RAM read per cycle; the compare works on the registered read data in the next cycle
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_idx_reg;
                if (scan_next_count == limit_reg)
                begin
                    state_next = bfa_pkg::ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = bfa_pkg::IDX_BITS'(scan_next_count);
                end
            end

            bfa_pkg::ST_DRAIN:
            begin
                state_next = bfa_pkg::ST_COMMIT;
            end

            bfa_pkg::ST_COMMIT:
            begin
                if (commit_fire)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = found_reg;
                    if (found_reg)
                    begin
                        used_next[best_idx_reg] = 1'b1;
                        out_chosen_next = bfa_pkg::CHOSEN_BITS'(best_idx_reg);
                        out_left_next   = bfa_pkg::LEFT_BITS'(best_left_reg);
                    end
                    else
                    begin
                        out_chosen_next = '0;
                        out_left_next   = '0;
                    end
                    state_next = bfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfa_pkg::ST_IDLE;
            count_reg     <= bfa_pkg::COUNT_RESET;
            used_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        request_reg     <= request_next;
        limit_reg       <= limit_next;
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        best_idx_reg    <= best_idx_next;
        best_left_reg   <= best_left_next;
        out_granted_reg <= out_granted_next;
        out_chosen_reg  <= out_chosen_next;
        out_left_reg    <= out_left_next;
    end

    // A granted commit marks the chosen block used
    a_commit_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (commit_fire && found_reg) |=> used_reg[best_idx_reg])
        else $error("granted block not marked used");

    // A refused result carries zero index and leftover
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.granted) |-> (rsp.chosen_block == '0 && rsp.leftover == '0))
        else $error("refused result has nonzero fields");

    // The scan never reads beyond the active block count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfa_pkg::ST_SCAN) |-> (bfa_pkg::CNT_BITS'(scan_idx_reg) < limit_reg))
        else $error("scan index beyond block count");

endmodule

[tb/tb.sv]
// Self-checking testbench for best_fit_block_allocator_unit: directed table, then random traffic.
module tb;

    localparam int DRAIN_CYCLES   = bfa_pkg::BLOCKS + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEGMENTS       = 9;
    localparam int SEG_ITEMS      = 110;

    typedef enum logic [1:0] {
        STEP_LOAD,
        STEP_ALLOC,
        STEP_SET_COUNT
    } step_op_t;

    typedef struct packed {
        logic                             granted;
        logic [bfa_pkg::CHOSEN_BITS-1:0]  chosen_block;
        logic [bfa_pkg::LEFT_BITS-1:0]    leftover;
    } alloc_result_t;

    typedef struct packed {
        step_op_t                         op;
        logic [bfa_pkg::SLOT_BITS-1:0]    slot;
        logic [bfa_pkg::AMOUNT_BITS-1:0]  amount;
        logic                             has_exp;
        alloc_result_t                    exp;
    } script_row_t;

    // Per-transfer note from the driver: a typed expectation, if any
    typedef struct packed {
        logic           has_exp;
        alloc_result_t  exp;
    } item_note_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [bfa_pkg::COUNT_BITS-1:0] cfg_wdata;

    bfa_req_if req_ch();
    bfa_rsp_if rsp_ch();

    best_fit_block_allocator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Mirror of the allocator state
    logic [bfa_pkg::SIZE_BITS-1:0]  size_tab [bfa_pkg::BLOCKS];
    logic [bfa_pkg::BLOCKS-1:0]     used_mask = '0;
    logic [bfa_pkg::COUNT_BITS-1:0] count_reg = bfa_pkg::COUNT_RESET;

    alloc_result_t grant_q [$];
    item_note_t    note_q  [$];
    script_row_t   script  [$];

    int error_count  = 0;
    int stall_cycles = 0;
    int send_idle_pct = 0;
    int rsp_idle_pct  = 0;

    // Driver-side view: which blocks hold a size, and the count in force
    logic [bfa_pkg::BLOCKS-1:0]     loaded_mask = '0;
    logic [bfa_pkg::COUNT_BITS-1:0] cur_count   = bfa_pkg::COUNT_RESET;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Best-fit search over the mirrored table; marks the winner used
    function automatic alloc_result_t best_fit_pick(
        input logic [bfa_pkg::AMOUNT_BITS-1:0] want_size);
        alloc_result_t                  res;
        int                             lim;
        logic                           found;
        logic [bfa_pkg::SIZE_BITS-1:0]  best_left;
        res = '0;
        found = 1'b0;
        best_left = '0;
        lim = (int'(count_reg) > bfa_pkg::BLOCKS) ? bfa_pkg::BLOCKS : int'(count_reg);
        for (int i = 0; i < lim; i++)
        begin
            if (!used_mask[i] && size_tab[i] >= want_size)
            begin
                if (!found || (size_tab[i] - want_size) < best_left)
                begin
                    found = 1'b1;
                    best_left = size_tab[i] - want_size;
                    res.chosen_block = bfa_pkg::CHOSEN_BITS'(i);
                end
            end
        end
        if (found)
        begin
            used_mask[res.chosen_block] = 1'b1;
            res.granted = 1'b1;
            res.leftover = bfa_pkg::LEFT_BITS'(best_left);
        end
        else
            res = '0;
        return res;
    endfunction

    // Receiver back-pressure
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);

    // Monitor: track config writes, predict on request transfers, check responses
    always @(posedge clk)
    begin : monitor
        item_note_t    note;
        alloc_result_t pred;
        alloc_result_t want;
        logic          moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
                count_reg = cfg_wdata;

            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                note = '0;
                if (note_q.size() != 0)
                    note = note_q.pop_front();
                else
                    report_mismatch("request transfer with no item sent");
                if (req_ch.kind == bfa_pkg::KIND_LOAD)
                begin
                    size_tab[req_ch.block_slot] = req_ch.amount;
                    used_mask[req_ch.block_slot] = 1'b0;
                end
                else
                begin
                    pred = best_fit_pick(req_ch.amount);
                    grant_q.push_back(note.has_exp ? note.exp : pred);
                end
            end

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (grant_q.size() == 0)
                    report_mismatch($sformatf("unexpected result g=%0b blk=%0d left=%0d",
                        rsp_ch.granted, rsp_ch.chosen_block, rsp_ch.leftover));
                else
                begin
                    want = grant_q.pop_front();
                    if (rsp_ch.granted !== want.granted)
                        report_mismatch($sformatf("granted %0b, want %0b",
                            rsp_ch.granted, want.granted));
                    if (rsp_ch.chosen_block !== want.chosen_block)
                        report_mismatch($sformatf("chosen_block %0d, want %0d",
                            rsp_ch.chosen_block, want.chosen_block));
                    if (rsp_ch.leftover !== want.leftover)
                        report_mismatch($sformatf("leftover %0d, want %0d",
                            rsp_ch.leftover, want.leftover));
                end
            end

            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    // Watchdog: too long without any transfer
    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("best_fit_block_allocator_unit regression: fail");
        $finish;
    end

    function automatic script_row_t mk_row(input step_op_t op,
                                           input logic [bfa_pkg::SLOT_BITS-1:0] slot,
                                           input logic [bfa_pkg::AMOUNT_BITS-1:0] amt,
                                           input logic has_exp, input logic g,
                                           input logic [bfa_pkg::CHOSEN_BITS-1:0] c,
                                           input logic [bfa_pkg::LEFT_BITS-1:0] l);
        script_row_t r;
        r.op = op;
        r.slot = slot;
        r.amount = amt;
        r.has_exp = has_exp;
        r.exp.granted = g;
        r.exp.chosen_block = c;
        r.exp.leftover = l;
        return r;
    endfunction

    // Present one item and hold it until the transfer
    task automatic send_item(input logic kind, input logic [bfa_pkg::SLOT_BITS-1:0] slot,
                             input logic [bfa_pkg::AMOUNT_BITS-1:0] amt,
                             input logic has_exp, input alloc_result_t exp);
        item_note_t note;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        note.has_exp = has_exp;
        note.exp = exp;
        note_q.push_back(note);
        if (kind == bfa_pkg::KIND_LOAD)
            loaded_mask[slot] = 1'b1;
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.block_slot <= slot;
        req_ch.amount     <= amt;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Register write, only once the unit has gone idle
    task automatic write_block_count(input logic [bfa_pkg::COUNT_BITS-1:0] value);
        req_ch.valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_count = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sizes and requests: mostly small so fits and misses both happen
    function automatic logic [bfa_pkg::AMOUNT_BITS-1:0] pick_amount();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return bfa_pkg::AMOUNT_BITS'($urandom_range(63));
        else if (r < 80)
            return bfa_pkg::AMOUNT_BITS'($urandom);
        else if (r < 90)
            return bfa_pkg::AMOUNT_BITS'(16'hFFFF - $urandom_range(3));
        else
            return bfa_pkg::AMOUNT_BITS'($urandom_range(3));
    endfunction

    // One random item; an allocate that would see a never-loaded block becomes a load of it
    task automatic send_random_item();
        int                             lim;
        logic [bfa_pkg::BLOCKS-1:0]     missing;
        logic [bfa_pkg::SLOT_BITS-1:0]  slot;
        logic                           kind;
        lim = (int'(cur_count) > bfa_pkg::BLOCKS) ? bfa_pkg::BLOCKS : int'(cur_count);
        missing = '0;
        for (int i = 0; i < lim; i++)
            missing[i] = !loaded_mask[i];
        kind = $urandom_range(1) ? bfa_pkg::KIND_ALLOC : bfa_pkg::KIND_LOAD;
        slot = bfa_pkg::SLOT_BITS'($urandom_range(bfa_pkg::BLOCKS - 1));
        if (kind == bfa_pkg::KIND_ALLOC && missing != '0)
        begin
            kind = bfa_pkg::KIND_LOAD;
            for (int i = bfa_pkg::BLOCKS - 1; i >= 0; i--)
                if (missing[i])
                    slot = bfa_pkg::SLOT_BITS'(i);
        end
        send_item(kind, slot, pick_amount(), 1'b0, '0);
    endtask

    // Stimulus
    initial
    begin : stimulus
        int count_plan [SEGMENTS];
        script_row_t row;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= bfa_pkg::KIND_LOAD;
        req_ch.block_slot <= '0;
        req_ch.amount     <= '0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;

        // Directed cases: empty window, single block, best fit with tie, exact fit
        script.push_back(mk_row(STEP_SET_COUNT, 0, 0,        0, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 0,        1, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 16'hFFFF, 1, 0, 0, 0));
        script.push_back(mk_row(STEP_LOAD,      0, 16'hFFFF, 0, 0, 0, 0));
        script.push_back(mk_row(STEP_SET_COUNT, 0, 1,        0, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 16'hFFFF, 1, 1, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 0,        1, 0, 0, 0));
        script.push_back(mk_row(STEP_LOAD,      0, 16'hFFFF, 0, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 0,        1, 1, 0, 16'hFFFF));
        script.push_back(mk_row(STEP_LOAD,      1, 100,      0, 0, 0, 0));
        script.push_back(mk_row(STEP_LOAD,      2, 50,       0, 0, 0, 0));
        script.push_back(mk_row(STEP_LOAD,      3, 50,       0, 0, 0, 0));
        script.push_back(mk_row(STEP_LOAD,      0, 200,      0, 0, 0, 0));
        script.push_back(mk_row(STEP_SET_COUNT, 0, 4,        0, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 40,       0, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 40,       0, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 40,       0, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 201,      1, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 200,      1, 1, 0, 0));
        script.push_back(mk_row(STEP_LOAD,      15, 16'hAAAA, 0, 0, 0, 0));
        script.push_back(mk_row(STEP_LOAD,      3, 16'h5555, 0, 0, 0, 0));
        script.push_back(mk_row(STEP_ALLOC,     0, 16'h5555, 0, 0, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, sender and receiver at full rate
        foreach (script[i])
        begin
            row = script[i];
            if (row.op == STEP_SET_COUNT)
                write_block_count(bfa_pkg::COUNT_BITS'(row.amount));
            else
                send_item((row.op == STEP_ALLOC) ? bfa_pkg::KIND_ALLOC : bfa_pkg::KIND_LOAD,
                          row.slot, row.amount, row.has_exp, row.exp);
        end

        // Random part: count settings include full, above table, zero and one
        count_plan = '{16, 31, 0, 1, 17, $urandom_range(31), 7, $urandom_range(31), 16};
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 3)
                0:
                begin
                    send_idle_pct = 38;
                    rsp_idle_pct  = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    rsp_idle_pct  = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rsp_idle_pct  = 0;
                end
            endcase
            write_block_count(bfa_pkg::COUNT_BITS'(count_plan[seg]));
            for (int n = 0; n < SEG_ITEMS; n++)
                send_random_item();
        end

        // Drain
        req_ch.valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("best_fit_block_allocator_unit regression: pass");
        else
            $display("best_fit_block_allocator_unit regression: fail");
        $finish;
    end

endmodule
